[hw/rtl/spq_pkg.sv]
// Package for the sorted priority queue: opcode and status codes, and the
// command and control types that the top level sends to each storage cell.
// Depends on nothing; imported by spq_cell, sorted_priority_queue_top, spq_checker and the testbench.
`default_nettype none

package spq_pkg;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Operation codes carried in the input tuser.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_POP    = 2'd2;

  // Result status codes carried in the output tuser.
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // What a cell does with its contents at the next edge.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN
  } cell_cmd_e;

  typedef struct packed {
    logic      cmp;  // capture the key comparison for the item being accepted
    cell_cmd_e cmd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One storage cell of the queue chain: a key, a payload and a registered
// "key not less than new key" flag. Depends on spq_pkg.
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16
) (
  input  wire                     clk_i,
  input  wire  cell_ctrl_t        ctrl_i,
  input  wire                     occupied_i,
  input  wire  [KEY_BITS-1:0]     new_key_i,
  input  wire  [PAYLOAD_BITS-1:0] new_payload_i,
  input  wire  [KEY_BITS-1:0]     lower_key_i,
  input  wire  [PAYLOAD_BITS-1:0] lower_payload_i,
  input  wire  [KEY_BITS-1:0]     upper_key_i,
  input  wire  [PAYLOAD_BITS-1:0] upper_payload_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    ge_o
);

  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic                    ge_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      ge_q <= occupied_i && (key_q >= new_key_i);
    end
    case (ctrl_i.cmd)
      CMD_LOAD: begin
        key_q     <= new_key_i;
        payload_q <= new_payload_i;
      end
      CMD_SHIFT_UP: begin
        key_q     <= lower_key_i;
        payload_q <= lower_payload_i;
      end
      CMD_SHIFT_DOWN: begin
        key_q     <= upper_key_i;
        payload_q <= upper_payload_i;
      end
      default: begin
        key_q     <= key_q;
        payload_q <= payload_q;
      end
    endcase
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign ge_o      = ge_q;

endmodule

`default_nettype wire

[hw/rtl/spq_scan.sv]
// Log-depth suffix OR over the per-cell compare flags: bit j is set when any
// cell at index j or above holds a key not less than the new key. No package use.
`default_nettype none

module spq_scan #(
  parameter int DEPTH = 64
) (
  input  wire  [DEPTH-1:0] flags_i,
  output logic [DEPTH-1:0] any_at_or_above_o
);

  localparam int LEVELS = $clog2(DEPTH);

  logic [DEPTH-1:0] level_v [0:LEVELS];

  always_comb begin
    level_v[0] = flags_i;
    for (int l = 0; l < LEVELS; l++) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (j + (1 << l) < DEPTH) begin
          level_v[l+1][j] = level_v[l][j] | level_v[l][j + (1 << l)];
        end else begin
          level_v[l+1][j] = level_v[l][j];
        end
      end
    end
  end

  assign any_at_or_above_o = level_v[LEVELS];

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue_top.sv]
// Sorted priority queue of up to DEPTH entries kept in a chain of cells, with
// the tail (largest key while order holds) always in cell 0 and the head in
// cell count-1. Each input beat carries an opcode in tuser (insert sorted,
// append at tail, pop tail) and a key and payload in tdata; each one yields
// exactly one output beat with a status in tuser and the popped key, popped
// payload and new entry count in tdata. For each item, on the
// accept edge every cell compares its key with the new key in parallel, and
// in the execute state a log-depth OR scan over those flags picks the insert
// point while every cell loads, holds or shifts to its neighbor at once. The
// execute state waits only while the single output register still holds a
// result that has not been taken. Input ready is low during the execute
// state. Storage needs no clearing after reset; cells at or above the count
// are never read. Depends on spq_pkg, spq_cell and spq_scan.
`default_nettype none

module sorted_priority_queue_top
  import spq_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int IN_DATA_W   = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((KEY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Input stream.
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: key [KEY_BITS-1:0], payload above it, zero padding.
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode.
  input  wire  [OP_W-1:0]       s_axis_tuser,
  // Output stream.
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // tdata: popped_key, popped_payload, entry_count, zero padding.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status.
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  logic [OP_W-1:0]         op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [CNT_W-1:0]        count_q, count_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_status_q, out_status_d;
  logic [KEY_BITS-1:0]     out_key_q, out_key_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;
  logic [CNT_W-1:0]        out_count_q;

  logic [KEY_BITS-1:0]     in_key;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic [KEY_BITS-1:0]     cell_new_key;

  logic accept, commit, full, empty, is_store, is_pop, write_ok;

  logic [KEY_BITS-1:0]     cell_key     [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
  logic [DEPTH-1:0]        ge_w;
  logic [DEPTH-1:0]        ge_above;
  logic [DEPTH-1:0]        below_ge;
  cell_ctrl_t              ctrl_w [DEPTH];

  assign in_key     = s_axis_tdata[KEY_BITS-1:0];
  assign in_payload = s_axis_tdata[KEY_BITS +: PAYLOAD_BITS];

  // A beat is taken only between items; the result register is checked later.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);

  assign full     = (count_q == CNT_W'(DEPTH));
  assign empty    = (count_q == '0);
  assign is_store = (op_q == OP_INSERT) || (op_q == OP_APPEND);
  assign is_pop   = (op_q == OP_POP);
  assign write_ok = (is_store && !full) || (is_pop && !empty);

  // The compare runs on the accept edge against the incoming key; loads use
  // the latched key.
  assign cell_new_key = (state_q == ST_IDLE) ? in_key : key_q;

  spq_scan #(
    .DEPTH(DEPTH)
  ) u_scan (
    .flags_i           (ge_w),
    .any_at_or_above_o (ge_above)
  );

  // Cell j loads the new entry on an insert when it is the lowest cell with no
  // matching cell at or above it, i.e. just above the highest matching cell.
  assign below_ge = {ge_w[DEPTH-2:0], 1'b1};

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [KEY_BITS-1:0]     lower_key, upper_key;
    logic [PAYLOAD_BITS-1:0] lower_payload, upper_payload;
    logic                    occupied;

    assign occupied = (CNT_W'(j) < count_q);

    if (j == 0) begin : g_first
      assign lower_key     = cell_key[j];
      assign lower_payload = cell_payload[j];
    end else begin : g_mid_lo
      assign lower_key     = cell_key[j-1];
      assign lower_payload = cell_payload[j-1];
    end

    if (j == DEPTH - 1) begin : g_last
      assign upper_key     = cell_key[j];
      assign upper_payload = cell_payload[j];
    end else begin : g_mid_hi
      assign upper_key     = cell_key[j+1];
      assign upper_payload = cell_payload[j+1];
    end

    always_comb begin
      ctrl_w[j].cmp = accept;
      ctrl_w[j].cmd = CMD_HOLD;
      if (commit && write_ok) begin
        case (op_q)
          OP_INSERT: begin
            if (ge_above[j]) begin
              ctrl_w[j].cmd = CMD_HOLD;
            end else if (below_ge[j]) begin
              ctrl_w[j].cmd = CMD_LOAD;
            end else begin
              ctrl_w[j].cmd = CMD_SHIFT_UP;
            end
          end
          OP_APPEND: begin
            ctrl_w[j].cmd = (j == 0) ? CMD_LOAD : CMD_SHIFT_UP;
          end
          OP_POP: begin
            ctrl_w[j].cmd = CMD_SHIFT_DOWN;
          end
          default: begin
            ctrl_w[j].cmd = CMD_HOLD;
          end
        endcase
      end
    end

    spq_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl_w[j]),
      .occupied_i      (occupied),
      .new_key_i       (cell_new_key),
      .new_payload_i   (payload_q),
      .lower_key_i     (lower_key),
      .lower_payload_i (lower_payload),
      .upper_key_i     (upper_key),
      .upper_payload_i (upper_payload),
      .key_o           (cell_key[j]),
      .payload_o       (cell_payload[j]),
      .ge_o            (ge_w[j])
    );
  end

  // Result of the item in execution; popped fields are zero unless a pop
  // actually removed an entry.
  always_comb begin
    count_d       = count_q;
    out_status_d  = STATUS_DONE;
    out_key_d     = '0;
    out_payload_d = '0;
    case (op_q)
      OP_INSERT, OP_APPEND: begin
        if (full) begin
          out_status_d = STATUS_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          out_status_d = STATUS_EMPTY;
        end else begin
          count_d       = count_q - 1'b1;
          out_key_d     = cell_key[0];
          out_payload_d = cell_payload[0];
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= s_axis_tuser;
      key_q     <= in_key;
      payload_q <= in_payload;
    end
    if (commit) begin
      out_status_q  <= out_status_d;
      out_key_q     <= out_key_d;
      out_payload_q <= out_payload_d;
      out_count_q   <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_count_q, out_payload_q, out_key_q});

  // The stored count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A store into a queue with room grows the count by exactly one.
  a_store_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && is_store && !full |=> count_q == $past(count_q) + 1'b1)
    else $error("store did not grow the count by one");

  // A pop from a non-empty queue shrinks the count by one and reports done.
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && is_pop && !empty |=>
      (count_q == $past(count_q) - 1'b1) && (out_status_q == STATUS_DONE))
    else $error("pop did not shrink the count by one");

endmodule

`default_nettype wire

[test/spq_checker.sv]
`timescale 1ns / 1ps
// Checker for the sorted priority queue: watches the input and output streams,
// keeps its own copy of the queue and compares every result beat field by field.
// Depends on spq_pkg for the opcode and status codes.

module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH        = 64,
  parameter int KEY_BITS     = 8,
  parameter int PAYLOAD_BITS = 16,
  parameter int CNT_W        = 7,
  parameter int IN_DATA_W    = 24,
  parameter int OUT_DATA_W   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [OP_W-1:0]       in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic [STATUS_W-1:0]   out_user_i,
  output int                    err_cnt_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [CNT_W-1:0]        count;
  } queue_result_t;

  // Shadow of the queue: position 0 is the head, model_count-1 the tail.
  logic [KEY_BITS-1:0]     model_keys     [DEPTH];
  logic [PAYLOAD_BITS-1:0] model_payloads [DEPTH];
  int unsigned             model_count;
  queue_result_t           expected_q [$];
  queue_result_t           exp_r;
  queue_result_t           got_r;

  // Applies one operation to the shadow queue and returns the result it gives.
  function automatic queue_result_t apply_queue_op(logic [OP_W-1:0] op,
                                                   logic [KEY_BITS-1:0] k,
                                                   logic [PAYLOAD_BITS-1:0] p);
    queue_result_t r;
    int unsigned   pos;
    int unsigned   i;
    bit            found;
    r = '0;
    r.status = STATUS_DONE;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (model_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pos   = model_count;
          found = 1'b0;
          // A sorted insert goes in front of the first key that is not smaller.
          if (op == OP_INSERT) begin
            for (i = 0; i < model_count; i++) begin
              if (!found && !(model_keys[i] < k)) begin
                pos   = i;
                found = 1'b1;
              end
            end
          end
          for (i = model_count; i > pos; i--) begin
            model_keys[i]     = model_keys[i-1];
            model_payloads[i] = model_payloads[i-1];
          end
          model_keys[pos]     = k;
          model_payloads[pos] = p;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          model_count--;
          r.key     = model_keys[model_count];
          r.payload = model_payloads[model_count];
        end
      end
      default: begin
        // The unused opcode leaves the queue alone.
      end
    endcase
    r.count = model_count[CNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      err_cnt_o++;
    end
  endtask

  // Inputs are driven with nonblocking assignments, so this block sees the
  // values that were present at the edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_count = 0;
      expected_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_r.status  = out_user_i;
        got_r.key     = out_data_i[KEY_BITS-1:0];
        got_r.payload = out_data_i[KEY_BITS +: PAYLOAD_BITS];
        got_r.count   = out_data_i[KEY_BITS+PAYLOAD_BITS +: CNT_W];
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h tuser %h",
                 out_data_i, out_user_i);
          err_cnt_o++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("status", 32'(exp_r.status), 32'(got_r.status));
          check_field("popped_key", 32'(exp_r.key), 32'(got_r.key));
          check_field("popped_payload", 32'(exp_r.payload), 32'(got_r.payload));
          check_field("entry_count", 32'(exp_r.count), 32'(got_r.count));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.push_back(apply_queue_op(in_user_i, in_data_i[KEY_BITS-1:0],
                                            in_data_i[KEY_BITS +: PAYLOAD_BITS]));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[test/tb_sorted_priority_queue_top.sv]
`timescale 1ns / 1ps
// Testbench top for the sorted priority queue: clock, reset, stimulus and the
// verdict. Depends on spq_pkg, sorted_priority_queue_top and spq_checker.

module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int KEY_BITS     = 8;
  localparam int PAYLOAD_BITS = 16;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IN_DATA_W    = ((KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((KEY_BITS + PAYLOAD_BITS + CNT_W + 7) / 8) * 8;

  // The opcode that the block has no operation for.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASE_BEATS   = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int MIXED_PCT     = 42;
  localparam int FILL_PCT      = 75;
  localparam int EMPTY_PCT     = 5;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // tdata: key, payload, from the lowest bit up.
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // tuser: opcode.
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // tdata: popped_key, popped_payload, entry_count, zero padding.
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // tuser: status.
  logic [STATUS_W-1:0]   m_axis_tuser;

  int   err_cnt;
  int   pending;
  bit   idling_on = 1'b0;
  int   hold_off_reqs = 0;
  int   stall_cycles = 0;

  sorted_priority_queue_top #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spq_checker #(
    .DEPTH        (DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .CNT_W        (CNT_W),
    .IN_DATA_W    (IN_DATA_W),
    .OUT_DATA_W   (OUT_DATA_W)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  always #2 clk_i = ~clk_i;

  // Result side. A hold-off request keeps tready low for a long stretch so the
  // single output register fills and the block stops taking input beats.
  initial begin
    int hold_off_done;
    hold_off_done = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_reqs != hold_off_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_off_done++;
      end else if (idling_on) begin
        m_axis_tready <= ($urandom_range(99) >= 25);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_sorted_priority_queue_top NOT OK");
      $finish;
    end
  end

  // Offers one beat, waits for it to be taken, then maybe leaves a gap.
  // When no gap follows, tvalid stays high into the next beat.
  task automatic send_beat(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] k,
                           logic [PAYLOAD_BITS-1:0] p);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {p, k};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (idling_on && $urandom_range(99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // One random beat. insert_pct steers the fill level: appends stay at ten
  // percent, the unused opcode at three, and pops take the rest.
  task automatic send_random(int unsigned insert_pct);
    int unsigned             r;
    logic [OP_W-1:0]         op;
    logic [KEY_BITS-1:0]     k;
    r = $urandom_range(99);
    if (r < 3) begin
      op = OP_UNUSED;
    end else if (r < 3 + insert_pct) begin
      op = OP_INSERT;
    end else if (r < 13 + insert_pct) begin
      op = OP_APPEND;
    end else begin
      op = OP_POP;
    end
    // Small keys make equal keys common; the extremes test the ends of the order.
    case ($urandom_range(3))
      0: k = KEY_BITS'($urandom_range(3));
      1: k = $urandom_range(1) ? '1 : '0;
      default: k = KEY_BITS'($urandom);
    endcase
    send_beat(op, k, PAYLOAD_BITS'($urandom));
  endtask

  // The count from the checker is read only after waiting on the clock, so it already holds
  // the beat accepted at the edge where this is called.
  task automatic wait_for_results();
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_INSERT;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty queue, ties, extremes, broken order, then drain.
    send_beat(OP_POP,    8'h00, 16'h0000);
    send_beat(OP_UNUSED, 8'hFF, 16'hFFFF);
    send_beat(OP_INSERT, 8'h80, 16'h1234);
    send_beat(OP_INSERT, 8'h00, 16'h0000);
    send_beat(OP_INSERT, 8'hFF, 16'hFFFF);
    send_beat(OP_INSERT, 8'h80, 16'hABCD);
    send_beat(OP_INSERT, 8'h00, 16'h5555);
    send_beat(OP_APPEND, 8'h01, 16'hAAAA);
    send_beat(OP_INSERT, 8'h40, 16'h0F0F);
    send_beat(OP_UNUSED, 8'h55, 16'h5555);
    send_beat(OP_INSERT, 8'hFF, 16'h8001);
    send_beat(OP_APPEND, 8'hFF, 16'h7FFE);
    repeat (10) send_beat(OP_POP, 8'h00, 16'h0000);

    // A stretch with no idling on either side.
    repeat (PHASE_BEATS) send_random(MIXED_PCT);

    // Fill to full while the result side holds off for a long time.
    idling_on = 1'b1;
    hold_off_reqs++;
    repeat (PHASE_BEATS) send_random(FILL_PCT);

    // Pause until every result is in, then drain well past empty.
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (PHASE_BEATS) send_random(EMPTY_PCT);

    hold_off_reqs++;
    repeat (PHASE_BEATS) send_random(FILL_PCT);
    repeat (PHASE_BEATS) send_random(MIXED_PCT);

    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_sorted_priority_queue_top OK");
    end else begin
      $display("tb_sorted_priority_queue_top NOT OK");
    end
    $finish;
  end

endmodule
